FILE: hw/rtl/dsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants for the decimal scale-up block
// Field positions of the flags word, queue entry type and status codes.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int WORD_W      = 32;
  localparam int IN_WORDS    = 3;
  localparam int STEPS_W     = 7;
  localparam int CNT_W       = 6;
  localparam int SIGN_BIT    = 31;
  localparam int SCALE_LSB   = 16;
  localparam int SCALE_W     = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0] SIGN_MASK  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] SCALE_MASK = 32'h00FF_0000;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    logic [IN_WORDS-1:0][WORD_W-1:0] mant;
    logic [WORD_W-1:0]               flags;
    logic [CNT_W-1:0]                steps;
    logic [SCALE_W-1:0]              raised_scale;
    logic                            err;
  } dsc_entry_t;

endpackage

FILE: hw/rtl/dsc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_in_if / dsc_out_if: valid-ready channels of the decimal scale-up block
// The input channel carries a mantissa, flags word and step count; the output
// channel carries the rescaled value and a status bit.
// ----------------------------------------------------------------------------
interface dsc_in_if;
  logic                                valid;
  logic                                ready;
  logic [dsc_pkg::WORD_W-1:0]          mant_low;
  logic [dsc_pkg::WORD_W-1:0]          mant_mid;
  logic [dsc_pkg::WORD_W-1:0]          mant_high;
  logic [dsc_pkg::WORD_W-1:0]          flags_word;
  logic signed [dsc_pkg::STEPS_W-1:0]  scale_steps;

  modport source (output valid, mant_low, mant_mid, mant_high, flags_word, scale_steps,
                  input ready);
  modport sink   (input valid, mant_low, mant_mid, mant_high, flags_word, scale_steps,
                  output ready);
endinterface

interface dsc_out_if;
  logic                       valid;
  logic                       ready;
  logic [dsc_pkg::WORD_W-1:0] res_low;
  logic [dsc_pkg::WORD_W-1:0] res_mid;
  logic [dsc_pkg::WORD_W-1:0] res_high;
  logic [dsc_pkg::WORD_W-1:0] res_flags;
  logic                       status;

  modport source (output valid, res_low, res_mid, res_high, res_flags, status,
                  input ready);
  modport sink   (input valid, res_low, res_mid, res_high, res_flags, status,
                  output ready);
endinterface

FILE: hw/rtl/dsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_front: request intake and classification
// Checks the step count and the scale limit and pushes a queue entry.
// ----------------------------------------------------------------------------
module dsc_front #(
  parameter int MAX_SCALE = 28
) (
  dsc_in_if.sink                out_req_unused_guard_n,
  input  logic                  q_ready,
  output logic                  q_push,
  output dsc_pkg::dsc_entry_t   q_entry
);

  logic [dsc_pkg::SCALE_W-1:0] old_scale;
  logic [dsc_pkg::SCALE_W:0]   scale_sum;
  logic                        bad_count;
  logic                        over_limit;

  // Accept whenever the queue has room.
  assign out_req_unused_guard_n.ready = q_ready;
  assign q_push = out_req_unused_guard_n.valid & q_ready;

  // Classify: a count that is zero or negative, or a scale past the limit.
  always_comb begin
    old_scale  = out_req_unused_guard_n.flags_word[dsc_pkg::SCALE_LSB +: dsc_pkg::SCALE_W];
    bad_count  = out_req_unused_guard_n.scale_steps[dsc_pkg::STEPS_W-1] ||
                 (out_req_unused_guard_n.scale_steps == '0);
    scale_sum  = {1'b0, old_scale} +
                 (dsc_pkg::SCALE_W+1)'(out_req_unused_guard_n.scale_steps[dsc_pkg::CNT_W-1:0]);
    over_limit = scale_sum > (dsc_pkg::SCALE_W+1)'(MAX_SCALE);

    q_entry.mant         = {out_req_unused_guard_n.mant_high, out_req_unused_guard_n.mant_mid,
                            out_req_unused_guard_n.mant_low};
    q_entry.flags        = out_req_unused_guard_n.flags_word;
    q_entry.steps        = out_req_unused_guard_n.scale_steps[dsc_pkg::CNT_W-1:0];
    q_entry.raised_scale = scale_sum[dsc_pkg::SCALE_W-1:0];
    q_entry.err          = bad_count | over_limit;
  end

endmodule

FILE: hw/rtl/dsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_queue: short request queue between front and back
// A small FIFO of classified entries so each side can stall on its own.
// ----------------------------------------------------------------------------
module dsc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dsc_pkg::dsc_entry_t push_entry,
  output logic                push_ready,
  input  logic                pop,
  output logic                pop_valid,
  output dsc_pkg::dsc_entry_t pop_entry
);

  localparam int PTR_W = (dsc_pkg::QUEUE_DEPTH > 1) ? $clog2(dsc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(dsc_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(dsc_pkg::QUEUE_DEPTH - 1);

  dsc_pkg::dsc_entry_t slot_r [dsc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  assign push_ready = count_r != CNT_W'(dsc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = slot_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push && push_ready, pop && pop_valid})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hw/rtl/dsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_back: iterative multiply-by-ten engine and result register
// Runs one x*8 + x*2 step per cycle on the mantissa and watches for carry out.
// ----------------------------------------------------------------------------
module dsc_back #(
  parameter int MANT_WORDS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  dsc_pkg::dsc_entry_t q_entry,
  output logic                q_pop,
  dsc_out_if.source           out_chan
);

  localparam int MW = MANT_WORDS * dsc_pkg::WORD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                     state_r;
  dsc_pkg::dsc_entry_t        hold_r;
  logic [MW-1:0]              work_r;
  logic [dsc_pkg::CNT_W-1:0]  cnt_r;
  logic                       err_r;
  logic                       out_valid_r;
  logic [dsc_pkg::WORD_W-1:0] res_low_r;
  logic [dsc_pkg::WORD_W-1:0] res_mid_r;
  logic [dsc_pkg::WORD_W-1:0] res_high_r;
  logic [dsc_pkg::WORD_W-1:0] res_flags_r;
  logic                       status_r;
  logic [MW+3:0]              tenx;
  logic                       carry_out;
  logic [dsc_pkg::WORD_W-1:0] ok_flags;
  logic                       load_out;

  // One multiply-by-ten step; anything above the mantissa is an overflow.
  assign tenx      = ({4'b0000, work_r} << 3) + ({4'b0000, work_r} << 1);
  assign carry_out = tenx[MW+3:MW] != 4'b0000;

  assign ok_flags = (hold_r.flags & dsc_pkg::SIGN_MASK) |
                    (dsc_pkg::WORD_W'(hold_r.raised_scale) << dsc_pkg::SCALE_LSB);

  assign q_pop = (state_r == S_IDLE) && q_valid;

  // The result register takes a finished request once it is empty or being drained.
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign out_chan.valid     = out_valid_r;
  assign out_chan.res_low   = res_low_r;
  assign out_chan.res_mid   = res_mid_r;
  assign out_chan.res_high  = res_high_r;
  assign out_chan.res_flags = res_flags_r;
  assign out_chan.status    = status_r;

  // Sequencer: load, iterate (skipped for a rejected request), then hand the result to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            hold_r  <= q_entry;
            work_r  <= MW'(q_entry.mant);
            cnt_r   <= q_entry.steps;
            err_r   <= q_entry.err;
            state_r <= q_entry.err ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (carry_out) begin
            err_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            work_r <= tenx[MW-1:0];
            cnt_r  <= cnt_r - 1'b1;
            if (cnt_r == dsc_pkg::CNT_W'(1)) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_r <= S_IDLE;
            if (err_r) begin
              res_low_r   <= hold_r.mant[0];
              res_mid_r   <= hold_r.mant[1];
              res_high_r  <= hold_r.mant[2];
              res_flags_r <= hold_r.flags;
              status_r    <= dsc_pkg::STATUS_ERR;
            end else begin
              res_low_r   <= work_r[0*dsc_pkg::WORD_W +: dsc_pkg::WORD_W];
              res_mid_r   <= work_r[1*dsc_pkg::WORD_W +: dsc_pkg::WORD_W];
              res_high_r  <= work_r[2*dsc_pkg::WORD_W +: dsc_pkg::WORD_W];
              res_flags_r <= ok_flags;
              status_r    <= dsc_pkg::STATUS_OK;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/decimal_scale_up_by_ten.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_scale_up_by_ten: raise the decimal scale of a 96-bit mantissa
// Multiplies the mantissa by ten a requested number of times and updates the
// scale field, or echoes the request with an error status.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request: three mantissa words, the flags word (sign in
//   bit 31, scale in bits 16 to 23) and a signed step count. out_chan returns
//   one result per request, in order, with status 0 on success, 1 on error.
//   A request moves when valid and ready are both high.
// Flow and throughput:
//   A taken request passes the queue, is loaded by the back end, runs its
//   steps and fills the result register; one rejected by count or scale
//   limit skips the steps, and one that overflows ends at the overflowing step.
//   The back end takes a new request only once the last is in the result
//   register; one shared shift-add unit does one multiply-by-ten per cycle.
// Reset and stalls:
//   Synchronous active-low reset empties the queue and the result register.
//   While the receiver stalls, the result holds; the front keeps accepting
//   until the two-entry queue is full, then drops in_chan.ready.
// ----------------------------------------------------------------------------
module decimal_scale_up_by_ten #(
  parameter int MANT_WORDS = 3,
  parameter int MAX_SCALE  = 28
) (
  input  logic       clk,
  input  logic       rst_n,
  dsc_in_if.sink     in_chan,
  dsc_out_if.source  out_chan
);

  logic                q_push;
  logic                q_push_ready;
  logic                q_pop;
  logic                q_pop_valid;
  dsc_pkg::dsc_entry_t q_push_entry;
  dsc_pkg::dsc_entry_t q_pop_entry;

  // Intake and classification.
  dsc_front #(
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .out_req_unused_guard_n (in_chan),
    .q_ready                (q_push_ready),
    .q_push                 (q_push),
    .q_entry                (q_push_entry)
  );

  // Decoupling queue.
  dsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_pop_valid),
    .pop_entry  (q_pop_entry)
  );

  // Iterative engine and result register.
  dsc_back #(
    .MANT_WORDS (MANT_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_pop_valid),
    .q_entry  (q_pop_entry),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

FILE: hw/rtl/dsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_checker: port-level assertions for the decimal scale-up block
// Checks reset behavior, result hold under stall and the shape of good results.
// ----------------------------------------------------------------------------
module dsc_checker #(
  parameter int MAX_SCALE = 28
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dsc_pkg::WORD_W-1:0] res_low,
  input logic [dsc_pkg::WORD_W-1:0] res_mid,
  input logic [dsc_pkg::WORD_W-1:0] res_high,
  input logic [dsc_pkg::WORD_W-1:0] res_flags,
  input logic                       status
);

  logic [dsc_pkg::SCALE_W-1:0] res_scale;
  assign res_scale = res_flags[dsc_pkg::SCALE_LSB +: dsc_pkg::SCALE_W];

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(res_low) && $stable(res_mid) &&
                                  $stable(res_high) && $stable(res_flags) && $stable(status))
    else $error("stalled result changed");

  // A good result keeps only the sign and the scale field.
  a_flags_clean: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (status == dsc_pkg::STATUS_OK) |->
        (res_flags & ~(dsc_pkg::SIGN_MASK | dsc_pkg::SCALE_MASK)) == '0)
    else $error("good result has stray flag bits");

  // A good result has a scale that was raised and stays within the limit.
  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (status == dsc_pkg::STATUS_OK) |->
        (res_scale != '0) && (res_scale <= dsc_pkg::SCALE_W'(MAX_SCALE)))
    else $error("good result scale out of range");

endmodule

bind decimal_scale_up_by_ten dsc_checker #(
  .MAX_SCALE (MAX_SCALE)
) u_dsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .res_low   (out_chan.res_low),
  .res_mid   (out_chan.res_mid),
  .res_high  (out_chan.res_high),
  .res_flags (out_chan.res_flags),
  .status    (out_chan.status)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for decimal_scale_up_by_ten
// Drives requests with random gaps, stalls the result channel at random and
// compares every result field against an in-bench predictor of the rescale.
// ----------------------------------------------------------------------------
module tb;

  localparam int MANT_BITS     = dsc_pkg::IN_WORDS * dsc_pkg::WORD_W;
  localparam int MAX_SCALE     = 28;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_ITEMS  = 950;

  // One expected result of the block.
  typedef struct packed {
    logic [dsc_pkg::WORD_W-1:0] low;
    logic [dsc_pkg::WORD_W-1:0] mid;
    logic [dsc_pkg::WORD_W-1:0] high;
    logic [dsc_pkg::WORD_W-1:0] flags;
    logic                       status;
  } scaled_value_t;

  logic clk;
  logic rst_n;

  dsc_in_if  in_chan ();
  dsc_out_if out_chan ();

  decimal_scale_up_by_ten #(
    .MANT_WORDS (dsc_pkg::IN_WORDS),
    .MAX_SCALE  (MAX_SCALE)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  scaled_value_t scaled_q[$];
  int            fail_count = 0;
  bit            no_idle;
  int            idle_cycles = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict the result of one request.
  function automatic scaled_value_t predict_scale_up(
      logic [MANT_BITS-1:0] mant,
      logic [dsc_pkg::WORD_W-1:0] flags,
      logic signed [dsc_pkg::STEPS_W-1:0] steps);
    scaled_value_t   r;
    logic [MANT_BITS+3:0] acc;
    int              old_scale;
    int              count;
    bit              err;
    old_scale = int'(flags[dsc_pkg::SCALE_LSB +: dsc_pkg::SCALE_W]);
    count     = int'(steps);
    acc       = {4'b0, mant};
    err       = 1'b0;
    if (count <= 0) begin
      err = 1'b1;
    end else if (old_scale + count > MAX_SCALE) begin
      err = 1'b1;
    end else begin
      for (int k = 0; k < count && !err; k++) begin
        // Times ten as x*8 + x*2; anything above the mantissa width is overflow.
        acc = (acc << 3) + (acc << 1);
        if (acc[MANT_BITS +: 4] != 4'b0) begin
          err = 1'b1;
        end
      end
    end
    if (err) begin
      r.low    = mant[0 +: dsc_pkg::WORD_W];
      r.mid    = mant[dsc_pkg::WORD_W +: dsc_pkg::WORD_W];
      r.high   = mant[2*dsc_pkg::WORD_W +: dsc_pkg::WORD_W];
      r.flags  = flags;
      r.status = dsc_pkg::STATUS_ERR;
    end else begin
      r.low    = acc[0 +: dsc_pkg::WORD_W];
      r.mid    = acc[dsc_pkg::WORD_W +: dsc_pkg::WORD_W];
      r.high   = acc[2*dsc_pkg::WORD_W +: dsc_pkg::WORD_W];
      r.flags  = flags & dsc_pkg::SIGN_MASK;
      r.flags[dsc_pkg::SCALE_LSB +: dsc_pkg::SCALE_W] = dsc_pkg::SCALE_W'(old_scale + count);
      r.status = dsc_pkg::STATUS_OK;
    end
    return r;
  endfunction

  // Send one request after a random gap and record its expected result.
  task automatic send_request(logic [MANT_BITS-1:0] mant,
                              logic [dsc_pkg::WORD_W-1:0] flags,
                              logic signed [dsc_pkg::STEPS_W-1:0] steps);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.mant_low    <= mant[0 +: dsc_pkg::WORD_W];
    in_chan.mant_mid    <= mant[dsc_pkg::WORD_W +: dsc_pkg::WORD_W];
    in_chan.mant_high   <= mant[2*dsc_pkg::WORD_W +: dsc_pkg::WORD_W];
    in_chan.flags_word  <= flags;
    in_chan.scale_steps <= steps;
    do @(posedge clk); while (!in_chan.ready);
    scaled_q.push_back(predict_scale_up(mant, flags, steps));
  endtask

  function automatic logic [dsc_pkg::WORD_W-1:0] flags_with_scale(
      logic [dsc_pkg::WORD_W-1:0] other,
      logic [dsc_pkg::SCALE_W-1:0] scale);
    logic [dsc_pkg::WORD_W-1:0] f;
    f = other;
    f[dsc_pkg::SCALE_LSB +: dsc_pkg::SCALE_W] = scale;
    return f;
  endfunction

  function automatic logic [MANT_BITS-1:0] random_mant();
    return {$urandom(), $urandom(), $urandom()};
  endfunction

  // Counts that are zero or negative are rejected.
  task automatic test_count_not_positive();
    send_request(random_mant(), flags_with_scale(32'h0, 8'd3), 7'sd0);
    send_request(random_mant(), flags_with_scale(dsc_pkg::SIGN_MASK, 8'd0), -7'sd1);
    send_request(random_mant(), flags_with_scale(32'h0, 8'd0), -7'sd64);
  endtask

  // The old scale plus the count must not pass the maximum scale.
  task automatic test_scale_limit();
    send_request(96'd1, flags_with_scale(32'h0, 8'd28), 7'sd1);
    send_request(96'd1, flags_with_scale(32'h0, 8'd0), 7'sd28);
    send_request(96'd12345, flags_with_scale(dsc_pkg::SIGN_MASK, 8'd27), 7'sd1);
    send_request(96'd1, flags_with_scale(32'h0, 8'hFF), 7'sd1);
    send_request(96'd1, flags_with_scale(32'h0, 8'd0), 7'sd63);
    // Bits outside the sign and scale fields are ignored and then cleared.
    send_request(96'd99, flags_with_scale(32'h7F00_FFFF, 8'd5), 7'sd3);
    send_request(96'd99, flags_with_scale(32'hFFFF_FFFF, 8'd20), 7'sd8);
  endtask

  // Any step that carries out of 96 bits fails the whole request.
  task automatic test_overflow();
    send_request({MANT_BITS{1'b1}}, flags_with_scale(32'h0, 8'd0), 7'sd1);
    send_request(96'h1999_9999_9999_9999_9999_9999, flags_with_scale(32'h0, 8'd0), 7'sd1);
    send_request(96'h1999_9999_9999_9999_9999_999A, flags_with_scale(32'h0, 8'd0), 7'sd1);
    send_request(96'd7, flags_with_scale(dsc_pkg::SIGN_MASK, 8'd0), 7'sd28);
    send_request(96'd8, flags_with_scale(32'h0, 8'd0), 7'sd28);
    send_request(96'd1 << 80, flags_with_scale(32'h0, 8'd1), 7'sd5);
  endtask

  // Extreme mantissa and flags values.
  task automatic test_extremes();
    send_request(96'd0, flags_with_scale(32'h0, 8'd0), 7'sd28);
    send_request(96'd0, 32'hFFFF_FFFF, 7'sd1);
    send_request({MANT_BITS{1'b1}}, 32'hFFFF_FFFF, -7'sd64);
    send_request(96'd1, flags_with_scale(dsc_pkg::SIGN_MASK, 8'd0), 7'sd1);
  endtask

  // Mostly well-formed requests with random depth, the rest fully random.
  task automatic test_random(int n);
    logic [MANT_BITS-1:0]               mant;
    logic [dsc_pkg::WORD_W-1:0]         flags;
    logic signed [dsc_pkg::STEPS_W-1:0] steps;
    int                                 scale;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) < 7) begin
        scale = $urandom_range(0, MAX_SCALE - 1);
        mant  = random_mant() >> $urandom_range(0, MANT_BITS - 1);
        flags = flags_with_scale($urandom(), dsc_pkg::SCALE_W'(scale));
        steps = dsc_pkg::STEPS_W'($urandom_range(1, MAX_SCALE - scale));
      end else begin
        mant  = random_mant();
        flags = $urandom();
        steps = dsc_pkg::STEPS_W'($urandom());
      end
      send_request(mant, flags, steps);
    end
    no_idle = 1'b0;
  endtask

  // Result channel ready with a random stall per result.
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin : check_results
    scaled_value_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (scaled_q.size() == 0) begin
        $error("unexpected result: res_low %h res_mid %h res_high %h res_flags %h status %b",
               out_chan.res_low, out_chan.res_mid, out_chan.res_high,
               out_chan.res_flags, out_chan.status);
        fail_count++;
      end else begin
        want = scaled_q.pop_front();
        if (out_chan.res_low !== want.low) begin
          $error("res_low: expected %h, actual %h", want.low, out_chan.res_low);
          fail_count++;
        end
        if (out_chan.res_mid !== want.mid) begin
          $error("res_mid: expected %h, actual %h", want.mid, out_chan.res_mid);
          fail_count++;
        end
        if (out_chan.res_high !== want.high) begin
          $error("res_high: expected %h, actual %h", want.high, out_chan.res_high);
          fail_count++;
        end
        if (out_chan.res_flags !== want.flags) begin
          $error("res_flags: expected %h, actual %h", want.flags, out_chan.res_flags);
          fail_count++;
        end
        if (out_chan.status !== want.status) begin
          $error("status: expected %b, actual %b", want.status, out_chan.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    no_idle             = 1'b0;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.mant_low    <= '0;
    in_chan.mant_mid    <= '0;
    in_chan.mant_high   <= '0;
    in_chan.flags_word  <= '0;
    in_chan.scale_steps <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_count_not_positive();
    test_scale_limit();
    test_overflow();
    test_extremes();
    test_random(RANDOM_ITEMS);

    in_chan.valid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && scaled_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
